@@ hdl/markup_external_token_scanner_defines.svh @@
// assertion macros for the markup external token scanner
// no dependencies; included by files that carry concurrent assertions
`ifndef MARKUP_EXTERNAL_TOKEN_SCANNER_DEFINES_SVH
`define MARKUP_EXTERNAL_TOKEN_SCANNER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define METS_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define METS_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hdl/mets_pkg.sv @@
// shared constants, codes and character classes for the markup external token scanner
// no dependencies
package mets_pkg;

    localparam int LENGTH_BITS = 24;
    localparam int RUN_BITS    = 16;
    localparam int CH_W        = 21;
    localparam int OUT_LEN_W   = 24;
    localparam int STEPS       = 8;

    localparam int S_TDATA_W = 32;
    localparam int M_TDATA_W = 56;

    typedef logic [LENGTH_BITS-1:0] len_t;
    typedef logic [RUN_BITS-1:0]    run_t;
    typedef logic [CH_W-1:0]        ch_t;

    typedef enum logic [1:0] {
        CMD_BEGIN = 2'd0,
        CMD_CHAR  = 2'd1,
        CMD_EOF   = 2'd2,
        CMD_NONE  = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_SCALAR = 2'd0,
        KIND_MARKER = 2'd1,
        KIND_GAP    = 2'd2,
        KIND_FENCE  = 2'd3
    } kind_t;

    // allowed token bits
    localparam int ALLOW_SCALAR = 0;
    localparam int ALLOW_MARKER = 1;
    localparam int ALLOW_GAP    = 2;
    localparam int ALLOW_FENCE  = 3;

    localparam run_t MIN_FENCE = run_t'(3);

    localparam ch_t CH_TAB    = ch_t'(9);
    localparam ch_t CH_LF     = ch_t'(10);
    localparam ch_t CH_CR     = ch_t'(13);
    localparam ch_t CH_SPACE  = ch_t'(32);
    localparam ch_t CH_PLUS   = ch_t'(43);
    localparam ch_t CH_COMMA  = ch_t'(44);
    localparam ch_t CH_MINUS  = ch_t'(45);
    localparam ch_t CH_DOT    = ch_t'(46);
    localparam ch_t CH_LPAREN = ch_t'(40);
    localparam ch_t CH_RPAREN = ch_t'(41);
    localparam ch_t CH_ZERO   = ch_t'(48);
    localparam ch_t CH_NINE   = ch_t'(57);
    localparam ch_t CH_COLON  = ch_t'(58);
    localparam ch_t CH_UP_A   = ch_t'(65);
    localparam ch_t CH_UP_Z   = ch_t'(90);
    localparam ch_t CH_LBRACK = ch_t'(91);
    localparam ch_t CH_RBRACK = ch_t'(93);
    localparam ch_t CH_UNDER  = ch_t'(95);
    localparam ch_t CH_LO_A   = ch_t'(97);
    localparam ch_t CH_LO_Z   = ch_t'(122);
    localparam ch_t CH_LBRACE = ch_t'(123);
    localparam ch_t CH_RBRACE = ch_t'(125);

    function automatic len_t sat_len(input len_t v);
        sat_len = (v == '1) ? v : len_t'(v + 1'b1);
    endfunction

    function automatic run_t sat_run(input run_t v);
        sat_run = (v == '1) ? v : run_t'(v + 1'b1);
    endfunction

    function automatic logic is_id_first(input ch_t c);
        is_id_first = (c == CH_UNDER) || (c >= CH_UP_A && c <= CH_UP_Z) ||
                      (c >= CH_LO_A && c <= CH_LO_Z);
    endfunction

    function automatic logic is_id_more(input ch_t c);
        is_id_more = is_id_first(c) || (c >= CH_ZERO && c <= CH_NINE) ||
                     (c == CH_DOT) || (c == CH_MINUS);
    endfunction

    function automatic logic is_stop(input ch_t c);
        is_stop = (c == CH_COMMA) || (c == CH_LPAREN) || (c == CH_RPAREN) ||
                  (c == CH_COLON) || (c == CH_LBRACK) || (c == CH_RBRACK) ||
                  (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LF) ||
                  (c == CH_CR);
    endfunction

endpackage

@@ hdl/markup_external_token_scanner.sv @@
// markup external token scanner top level: input register, scanner state, result register
// depends on mets_pkg and markup_external_token_scanner_defines.svh
//
//  channel | direction | tdata (lsb first)                              | tuser
//  s_      | in        | ch[20:0], valid_scalar, valid_list_marker,     | cmd[1:0]
//          |           | valid_list_gap, valid_fence, zero pad to 32    |
//  m_      | out       | accepted, token_length[23:0],                  | token_kind[1:0]
//          |           | skipped_blanks[23:0], zero pad to 56           |
//
// one word per cycle sustained while no result is held on m_; a word is taken into the input register,
// from which it updates the scanner state and loads its result, if any, into the result register onto m_
// the scanner state update is one pass of a bounded phase chain per word
// aresetn is synchronous and clears valids and scanner state
// a held result stalls the scanner stage, which then backs up into s_tready

`include "markup_external_token_scanner_defines.svh"

module markup_external_token_scanner (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // ch, valid_scalar, valid_list_marker, valid_list_gap, valid_fence
    input  logic [mets_pkg::S_TDATA_W-1:0] s_tdata,
    // cmd
    input  logic [1:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // accepted, token_length, skipped_blanks
    output logic [mets_pkg::M_TDATA_W-1:0] m_tdata,
    // token_kind
    output logic [1:0]                    m_tuser
);
    import mets_pkg::*;

    typedef enum logic [4:0] {
        P_IDLE, P_DISPATCH,
        P_F_LEAD, P_F_OPEN, P_F_SKIPLINE, P_F_LINE, P_F_AFTER_CR, P_F_RUN, P_F_TRAIL,
        P_L_LEAD, P_L_BODY, P_L_CLOSE, P_L_DECIDE,
        P_S_LEAD, P_S_IDENT, P_S_GAP, P_S_BODY
    } phase_t;

    // input register
    logic        in_valid_reg;
    cmd_t        in_cmd_reg;
    ch_t         in_ch_reg;
    logic [3:0]  in_allow_reg;

    // scanner state
    phase_t      phase_reg, phase_next;
    logic [3:0]  allow_reg;
    run_t        open_run_reg, open_run_next;
    run_t        line_run_reg, line_run_next;
    len_t        consumed_reg, consumed_next;
    len_t        skipped_reg, skipped_next;
    logic        saw_blank_reg, saw_blank_next;

    // result register
    logic        out_valid_reg;
    logic        out_ok_reg;
    kind_t       out_kind_reg;
    logic [OUT_LEN_W-1:0] out_len_reg;
    logic [OUT_LEN_W-1:0] out_skip_reg;

    logic        proc_fire;
    logic        is_begin;
    logic        active;
    logic        eof;
    ch_t         c;
    logic        blank, nl, plus;
    logic        run_ge;
    phase_t      ph;
    logic        done, emit, ok;
    kind_t       kind;
    logic        inc_skip, inc_cons, inc_open, inc_line, set_saw, clr_line;

    assign proc_fire = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || proc_fire;

    assign is_begin = (in_cmd_reg == CMD_BEGIN);
    assign active   = (in_cmd_reg == CMD_CHAR || in_cmd_reg == CMD_EOF) &&
                      (phase_reg != P_IDLE);
    assign eof      = (in_cmd_reg == CMD_EOF);
    assign c        = eof ? '0 : in_ch_reg;
    assign blank    = (c == CH_SPACE) || (c == CH_TAB);
    assign nl       = (c == CH_LF) || (c == CH_CR);
    assign plus     = (c == CH_PLUS);

    // bounded walk through the phase chain for one word
    always_comb begin
        ph       = phase_reg;
        done     = 1'b0;
        emit     = 1'b0;
        ok       = 1'b0;
        kind     = KIND_SCALAR;
        inc_skip = 1'b0;
        inc_cons = 1'b0;
        inc_open = 1'b0;
        inc_line = 1'b0;
        set_saw  = 1'b0;
        clr_line = 1'b0;
        run_ge   = 1'b0;
        for (int i = 0; i < STEPS; i++) begin
            if (!done) begin
                case (ph)
                    P_DISPATCH: begin
                        if (allow_reg[ALLOW_FENCE] && (plus || blank)) begin
                            ph = P_F_LEAD;
                        end else if (allow_reg[ALLOW_GAP] || allow_reg[ALLOW_MARKER]) begin
                            ph = P_L_LEAD;
                        end else if (allow_reg[ALLOW_SCALAR]) begin
                            ph = P_S_LEAD;
                        end else begin
                            done = 1'b1; emit = 1'b1; ph = P_IDLE;
                        end
                    end
                    P_F_LEAD: begin
                        if (blank) begin
                            inc_skip = 1'b1; done = 1'b1;
                        end else begin
                            ph = P_F_OPEN;
                        end
                    end
                    P_F_OPEN: begin
                        if (plus) begin
                            inc_open = 1'b1; inc_cons = 1'b1; done = 1'b1;
                        end else if (open_run_reg < MIN_FENCE) begin
                            done = 1'b1; emit = 1'b1; ph = P_IDLE;
                        end else begin
                            ph = P_F_SKIPLINE;
                        end
                    end
                    P_F_SKIPLINE: begin
                        if (eof || nl) begin
                            ph = P_F_LINE;
                        end else begin
                            inc_cons = 1'b1; done = 1'b1;
                        end
                    end
                    P_F_LINE: begin
                        if (eof) begin
                            done = 1'b1; emit = 1'b1; ok = 1'b1; kind = KIND_FENCE;
                            ph = P_IDLE;
                        end else begin
                            ph = P_F_AFTER_CR;
                            if (c == CH_CR) begin
                                inc_cons = 1'b1; done = 1'b1;
                            end
                        end
                    end
                    P_F_AFTER_CR: begin
                        clr_line = 1'b1;
                        ph = P_F_RUN;
                        if (c == CH_LF) begin
                            inc_cons = 1'b1; done = 1'b1;
                        end
                    end
                    P_F_RUN: begin
                        if (plus) begin
                            inc_line = 1'b1; inc_cons = 1'b1; done = 1'b1;
                        end else begin
                            run_ge = clr_line ? (open_run_reg == '0)
                                              : (line_run_reg >= open_run_reg);
                            ph = run_ge ? P_F_TRAIL : P_F_SKIPLINE;
                        end
                    end
                    P_F_TRAIL: begin
                        if (blank) begin
                            inc_cons = 1'b1; done = 1'b1;
                        end else if (eof || nl) begin
                            done = 1'b1; emit = 1'b1; ok = 1'b1; kind = KIND_FENCE;
                            ph = P_IDLE;
                        end else begin
                            ph = P_F_SKIPLINE;
                        end
                    end
                    P_L_LEAD: begin
                        if (blank) begin
                            inc_skip = 1'b1; set_saw = 1'b1; done = 1'b1;
                        end else if (allow_reg[ALLOW_MARKER] && c == CH_LPAREN) begin
                            inc_cons = 1'b1; ph = P_L_BODY; done = 1'b1;
                        end else begin
                            ph = P_L_DECIDE;
                        end
                    end
                    P_L_BODY: begin
                        if (c == CH_RPAREN) begin
                            inc_cons = 1'b1; ph = P_L_CLOSE; done = 1'b1;
                        end else if (eof || nl) begin
                            ph = P_L_DECIDE;
                        end else begin
                            inc_cons = 1'b1; done = 1'b1;
                        end
                    end
                    P_L_CLOSE: begin
                        if (blank) begin
                            done = 1'b1; emit = 1'b1; ok = 1'b1; kind = KIND_MARKER;
                            ph = P_IDLE;
                        end else begin
                            ph = P_L_DECIDE;
                        end
                    end
                    P_L_DECIDE: begin
                        done = 1'b1; emit = 1'b1; ph = P_IDLE;
                        if (allow_reg[ALLOW_GAP] && (saw_blank_reg || set_saw)) begin
                            ok = 1'b1; kind = KIND_GAP;
                        end
                    end
                    P_S_LEAD: begin
                        if (blank) begin
                            inc_skip = 1'b1; done = 1'b1;
                        end else if (eof || is_stop(c)) begin
                            done = 1'b1; emit = 1'b1; ph = P_IDLE;
                        end else begin
                            ph = is_id_first(c) ? P_S_IDENT : P_S_BODY;
                        end
                    end
                    P_S_IDENT: begin
                        if (is_id_more(c)) begin
                            inc_cons = 1'b1; done = 1'b1;
                        end else if (c == CH_COLON) begin
                            done = 1'b1; emit = 1'b1; ph = P_IDLE;
                        end else begin
                            ph = P_S_GAP;
                        end
                    end
                    P_S_GAP: begin
                        if (blank) begin
                            inc_cons = 1'b1; done = 1'b1;
                        end else if (c == CH_LBRACE) begin
                            done = 1'b1; emit = 1'b1; ph = P_IDLE;
                        end else begin
                            ph = P_S_BODY;
                        end
                    end
                    P_S_BODY: begin
                        if (eof || is_stop(c)) begin
                            done = 1'b1; emit = 1'b1; ok = 1'b1; kind = KIND_SCALAR;
                            ph = P_IDLE;
                        end else begin
                            inc_cons = 1'b1; done = 1'b1;
                        end
                    end
                    default: begin
                        ph = P_IDLE; done = 1'b1;
                    end
                endcase
            end
        end
    end

    always_comb begin
        phase_next     = phase_reg;
        open_run_next  = open_run_reg;
        line_run_next  = line_run_reg;
        consumed_next  = consumed_reg;
        skipped_next   = skipped_reg;
        saw_blank_next = saw_blank_reg;
        if (is_begin) begin
            phase_next     = P_DISPATCH;
            open_run_next  = '0;
            line_run_next  = '0;
            consumed_next  = '0;
            skipped_next   = '0;
            saw_blank_next = 1'b0;
        end else if (active) begin
            phase_next = ph;
            if (inc_open) begin
                open_run_next = sat_run(open_run_reg);
            end
            if (inc_line) begin
                line_run_next = clr_line ? run_t'(1) : sat_run(line_run_reg);
            end else if (clr_line) begin
                line_run_next = '0;
            end
            if (inc_cons) begin
                consumed_next = sat_len(consumed_reg);
            end
            if (inc_skip) begin
                skipped_next = sat_len(skipped_reg);
            end
            if (set_saw) begin
                saw_blank_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= P_IDLE;
            allow_reg     <= '0;
            open_run_reg  <= '0;
            line_run_reg  <= '0;
            consumed_reg  <= '0;
            skipped_reg   <= '0;
            saw_blank_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
            end else if (proc_fire) begin
                in_valid_reg <= 1'b0;
            end
            if (proc_fire) begin
                phase_reg     <= phase_next;
                open_run_reg  <= open_run_next;
                line_run_reg  <= line_run_next;
                consumed_reg  <= consumed_next;
                skipped_reg   <= skipped_next;
                saw_blank_reg <= saw_blank_next;
                if (is_begin) begin
                    allow_reg <= in_allow_reg;
                end
            end
            if (proc_fire && active && emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_cmd_reg   <= cmd_t'(s_tuser);
            in_ch_reg    <= s_tdata[CH_W-1:0];
            in_allow_reg <= s_tdata[CH_W+3:CH_W];
        end
        if (proc_fire && active && emit) begin
            out_ok_reg   <= ok;
            out_kind_reg <= ok ? kind : KIND_SCALAR;
            out_len_reg  <= ok ? OUT_LEN_W'(consumed_reg) : '0;
            out_skip_reg <= OUT_LEN_W'(skipped_reg);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {{(M_TDATA_W - 2*OUT_LEN_W - 1){1'b0}},
                       out_skip_reg, out_len_reg, out_ok_reg};

    `METS_ASSERT_NOW(a_reject_clean, aclk, aresetn,
        m_tvalid && !m_tdata[0], m_tuser == KIND_SCALAR && m_tdata[OUT_LEN_W:1] == '0,
        "rejected result carries nonzero kind or length")
    `METS_ASSERT_NEXT(a_result_idles, aclk, aresetn,
        proc_fire && active && emit, phase_reg == P_IDLE,
        "scanner not idle after a result")
    `METS_ASSERT_NEXT(a_begin_clears, aclk, aresetn,
        proc_fire && is_begin,
        phase_reg == P_DISPATCH && consumed_reg == '0 && skipped_reg == '0 && !saw_blank_reg,
        "begin word did not restart the scan")
    `METS_ASSERT_NEXT(a_idle_holds, aclk, aresetn,
        proc_fire && !is_begin && phase_reg == P_IDLE,
        phase_reg == P_IDLE && $stable(consumed_reg) && $stable(skipped_reg),
        "idle scanner changed on a non-begin word")

endmodule
